/* hw/rtl/tmon_pkg.sv */
// ----------------------------------------------------------------------------
// tmon_pkg: shared types and constants for the temperature threshold monitor
// Command and alarm codes, register indexes, reset values, item/result types.
// ----------------------------------------------------------------------------
`default_nettype none

package tmon_pkg;

    // command codes
    localparam logic [2:0] CMD_SAMPLE    = 3'd0;
    localparam logic [2:0] CMD_TICK      = 3'd1;
    localparam logic [2:0] CMD_LOW_DOWN  = 3'd2;
    localparam logic [2:0] CMD_LOW_UP    = 3'd3;
    localparam logic [2:0] CMD_HIGH_DOWN = 3'd4;
    localparam logic [2:0] CMD_HIGH_UP   = 3'd5;

    // alarm codes
    localparam logic [1:0] ALARM_NONE  = 2'd0;
    localparam logic [1:0] ALARM_ABOVE = 2'd1;
    localparam logic [1:0] ALARM_BELOW = 2'd2;

    // configuration register indexes
    localparam int unsigned CFG_ADDR_W = 2;
    localparam logic [CFG_ADDR_W-1:0] REG_WINDOW_LENGTH = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_LIMIT_FLOOR   = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_LIMIT_CEILING = 2'd2;
    localparam int unsigned CFG_DATA_W = 32;

    // reset values
    localparam logic [31:0]       WINDOW_LENGTH_RST = 32'd3600;
    localparam logic signed [7:0] LIMIT_FLOOR_RST   = -8'sd40;
    localparam logic signed [7:0] LIMIT_CEILING_RST = 8'sd125;
    localparam logic signed [7:0] LOW_LIMIT_RST     = 8'sd18;
    localparam logic signed [7:0] HIGH_LIMIT_RST    = 8'sd30;

    // default fraction bits of a sample
    localparam int FRAC_BITS_DEF = 8;

    // stream widths (fields packed from bit 0, padded to bytes)
    localparam int unsigned S_TDATA_W = 24;
    localparam int unsigned M_TDATA_W = 56;

    typedef struct packed {
        logic [2:0]         command;
        logic signed [15:0] sample_value;
    } tmon_item_t;

    typedef struct packed {
        logic               valid_out;
        logic signed [7:0]  high_out;
        logic signed [7:0]  low_out;
        logic signed [15:0] max_out;
        logic signed [15:0] min_out;
        logic [1:0]         alarm;
    } tmon_result_t;

endpackage

`default_nettype wire

/* hw/rtl/tmon_in_stage.sv */
// ----------------------------------------------------------------------------
// tmon_in_stage: input register
// Captures one input transaction; refills in the same cycle it drains.
// ----------------------------------------------------------------------------
`default_nettype none

module tmon_in_stage (
    input  wire                      clk,
    input  wire                      rst_n,
    input  wire                      in_valid,
    output logic                     in_ready,
    input  tmon_pkg::tmon_item_t     in_item,
    output logic                     item_valid,
    input  wire                      item_ready,
    output tmon_pkg::tmon_item_t     item
);

    logic                 valid_reg;
    logic                 valid_next;
    tmon_pkg::tmon_item_t item_reg;
    logic                 load;

    assign in_ready   = !valid_reg || item_ready;
    assign load       = in_valid && in_ready;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_comb
    begin
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (item_ready)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg <= in_item;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/tmon_core.sv */
// ----------------------------------------------------------------------------
// tmon_core: monitor state, single-pass update and result register
// Holds config, thresholds, window min/max and the tick counter.
// ----------------------------------------------------------------------------
`default_nettype none

module tmon_core #(
    parameter int FRAC_BITS = tmon_pkg::FRAC_BITS_DEF
) (
    input  wire                                 clk,
    input  wire                                 rst_n,
    input  wire                                 cfg_we,
    input  wire  [tmon_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  wire  [tmon_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  wire                                 item_valid,
    output logic                                item_ready,
    input  tmon_pkg::tmon_item_t                item,
    output logic                                result_valid,
    input  wire                                 result_ready,
    output tmon_pkg::tmon_result_t              result
);

    // compare width: sample or scaled threshold, plus a sign guard bit
    localparam int SCALED_W = 8 + FRAC_BITS;
    localparam int CMP_W    = ((SCALED_W > 16) ? SCALED_W : 16) + 1;

    logic [31:0]       window_length_reg;
    logic signed [7:0] limit_floor_reg;
    logic signed [7:0] limit_ceiling_reg;

    logic signed [7:0]  low_limit_reg,  low_limit_next;
    logic signed [7:0]  high_limit_reg, high_limit_next;
    logic signed [15:0] window_min_reg, window_min_next;
    logic signed [15:0] window_max_reg, window_max_next;
    logic               window_valid_reg, window_valid_next;
    logic [31:0]        elapsed_ticks_reg, elapsed_ticks_next;

    logic                   result_valid_reg, result_valid_next;
    tmon_pkg::tmon_result_t result_reg, result_next;

    logic               step;
    logic [1:0]         alarm;
    logic signed [8:0]  low_w, high_w, floor_w, ceil_w, t_low, t_high;
    logic signed [CMP_W-1:0] s_ext, hi_scaled, lo_scaled;
    logic [31:0]        elapsed_eff;
    logic               restart;

    assign item_ready   = !result_valid_reg || result_ready;
    assign step         = item_valid && item_ready;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_length_reg <= tmon_pkg::WINDOW_LENGTH_RST;
            limit_floor_reg   <= tmon_pkg::LIMIT_FLOOR_RST;
            limit_ceiling_reg <= tmon_pkg::LIMIT_CEILING_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                tmon_pkg::REG_WINDOW_LENGTH: window_length_reg <= cfg_wdata[31:0];
                tmon_pkg::REG_LIMIT_FLOOR:   limit_floor_reg   <= cfg_wdata[7:0];
                tmon_pkg::REG_LIMIT_CEILING: limit_ceiling_reg <= cfg_wdata[7:0];
                default: ;
            endcase
        end
    end

    // one item, one pass
    always_comb
    begin
        low_limit_next     = low_limit_reg;
        high_limit_next    = high_limit_reg;
        window_min_next    = window_min_reg;
        window_max_next    = window_max_reg;
        window_valid_next  = window_valid_reg;
        elapsed_ticks_next = elapsed_ticks_reg;
        alarm              = tmon_pkg::ALARM_NONE;

        low_w   = 9'(low_limit_reg);
        high_w  = 9'(high_limit_reg);
        floor_w = 9'(limit_floor_reg);
        ceil_w  = 9'(limit_ceiling_reg);
        t_low   = low_w;
        t_high  = high_w;

        s_ext     = CMP_W'(item.sample_value);
        hi_scaled = CMP_W'(high_limit_reg) <<< FRAC_BITS;
        lo_scaled = CMP_W'(low_limit_reg) <<< FRAC_BITS;

        // first sample counts as zero elapsed ticks
        elapsed_eff = window_valid_reg ? elapsed_ticks_reg : 32'd0;
        restart     = !window_valid_reg || (elapsed_eff >= window_length_reg);

        case (item.command)
            tmon_pkg::CMD_SAMPLE:
            begin
                window_valid_next = 1'b1;
                if (restart)
                begin
                    window_min_next    = item.sample_value;
                    window_max_next    = item.sample_value;
                    elapsed_ticks_next = 32'd0;
                end
                else
                begin
                    if (item.sample_value > window_max_reg)
                    begin
                        window_max_next = item.sample_value;
                    end
                    if (item.sample_value < window_min_reg)
                    begin
                        window_min_next = item.sample_value;
                    end
                end
                if (s_ext > hi_scaled)
                begin
                    alarm = tmon_pkg::ALARM_ABOVE;
                end
                else if (s_ext < lo_scaled)
                begin
                    alarm = tmon_pkg::ALARM_BELOW;
                end
            end
            tmon_pkg::CMD_TICK:
            begin
                if (elapsed_ticks_reg != '1)
                begin
                    elapsed_ticks_next = elapsed_ticks_reg + 32'd1;
                end
            end
            tmon_pkg::CMD_LOW_DOWN, tmon_pkg::CMD_LOW_UP:
            begin
                if (item.command == tmon_pkg::CMD_LOW_DOWN)
                begin
                    t_low = low_w - 9'sd1;
                    if (t_low < floor_w)
                    begin
                        t_low = floor_w;
                    end
                end
                else
                begin
                    t_low = low_w + 9'sd1;
                    if (t_low > ceil_w)
                    begin
                        t_low = ceil_w;
                    end
                end
                low_limit_next = t_low[7:0];
                if (high_w < t_low)
                begin
                    high_limit_next = t_low[7:0];
                end
            end
            tmon_pkg::CMD_HIGH_DOWN:
            begin
                t_high = high_w - 9'sd1;
                if (t_high < low_w)
                begin
                    t_high = low_w;
                end
                high_limit_next = t_high[7:0];
            end
            tmon_pkg::CMD_HIGH_UP:
            begin
                t_high = high_w + 9'sd1;
                if (t_high > ceil_w)
                begin
                    t_high = ceil_w;
                end
                if (t_high < low_w)
                begin
                    t_high = low_w;
                end
                high_limit_next = t_high[7:0];
            end
            default: ;
        endcase

        result_next.alarm     = alarm;
        result_next.min_out   = window_min_next;
        result_next.max_out   = window_max_next;
        result_next.low_out   = low_limit_next;
        result_next.high_out  = high_limit_next;
        result_next.valid_out = window_valid_next;

        if (step)
        begin
            result_valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            result_valid_next = 1'b0;
        end
        else
        begin
            result_valid_next = result_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_limit_reg     <= tmon_pkg::LOW_LIMIT_RST;
            high_limit_reg    <= tmon_pkg::HIGH_LIMIT_RST;
            window_min_reg    <= 16'sd0;
            window_max_reg    <= 16'sd0;
            window_valid_reg  <= 1'b0;
            elapsed_ticks_reg <= 32'd0;
            result_valid_reg  <= 1'b0;
        end
        else
        begin
            result_valid_reg <= result_valid_next;
            if (step)
            begin
                low_limit_reg     <= low_limit_next;
                high_limit_reg    <= high_limit_next;
                window_min_reg    <= window_min_next;
                window_max_reg    <= window_max_next;
                window_valid_reg  <= window_valid_next;
                elapsed_ticks_reg <= elapsed_ticks_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            result_reg <= result_next;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/temperature_threshold_monitor.sv */
// ----------------------------------------------------------------------------
// temperature_threshold_monitor: threshold alarms and windowed min/max
// Samples, ticks and threshold buttons in; one status transaction out per item.
// ----------------------------------------------------------------------------
//
//  channel   | direction | handshake                | payload
//  ----------+-----------+--------------------------+---------------------------
//  s_axis    | in        | s_tvalid / s_tready      | s_tdata: command, sample
//  m_axis    | out       | m_tvalid / m_tready      | m_tdata: alarm .. valid
//  cfg       | in        | cfg_we (always taken)    | cfg_addr, cfg_wdata
//
//  Throughput is one transaction per cycle while m_tready stays high; an
//  accepted input goes to the input register, then the single-pass update
//  loads the result register, which drives m_tvalid, with the monitor state.
//  rst_n clears both valid flags, the window and the tick counter, sets the
//  thresholds to 18 / 30 and loads the config reset values.
//  When m_tready is low the result register holds; the input register still
//  takes one more transaction, then s_tready drops until the result drains.
//  Config writes take effect the next cycle; issue them only while idle.
// ----------------------------------------------------------------------------
`default_nettype none

module temperature_threshold_monitor #(
    parameter int FRAC_BITS = tmon_pkg::FRAC_BITS_DEF
) (
    input  wire                                 clk,
    input  wire                                 rst_n,
    // config write port: 0 window_length, 1 limit_floor, 2 limit_ceiling
    input  wire                                 cfg_we,
    input  wire  [tmon_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  wire  [tmon_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    // input stream
    input  wire                                 s_tvalid,
    output logic                                s_tready,
    // s_tdata, lsb up: command[2:0], sample_value[18:3], zero pad [23:19]
    input  wire  [tmon_pkg::S_TDATA_W-1:0]      s_tdata,
    // result stream
    output logic                                m_tvalid,
    input  wire                                 m_tready,
    // m_tdata, lsb up: alarm[1:0], min_out[17:2], max_out[33:18],
    // low_out[41:34], high_out[49:42], valid_out[50], zero pad [55:51]
    output logic [tmon_pkg::M_TDATA_W-1:0]      m_tdata
);

    tmon_pkg::tmon_item_t   in_item;
    tmon_pkg::tmon_item_t   item;
    tmon_pkg::tmon_result_t result;
    logic                   item_valid;
    logic                   item_ready;

    // unpack the input transaction: command, then sample_value
    assign in_item = {s_tdata[2:0], s_tdata[18:3]};

    tmon_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_item    (in_item),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item)
    );

    tmon_core #(
        .FRAC_BITS (FRAC_BITS)
    ) u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_addr     (cfg_addr),
        .cfg_wdata    (cfg_wdata),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (m_tvalid),
        .result_ready (m_tready),
        .result       (result)
    );

    // pack the result, first field in the low bits
    assign m_tdata = {5'd0,
                      result.valid_out,
                      result.high_out,
                      result.low_out,
                      result.max_out,
                      result.min_out,
                      result.alarm};

endmodule

`default_nettype wire

/* hw/rtl/tmon_checker.sv */
// ----------------------------------------------------------------------------
// tmon_checker: port-level checks on the result stream
// Bound to the top level; watches only the m_axis ports.
// ----------------------------------------------------------------------------
`default_nettype none

module tmon_checker (
    input wire                              clk,
    input wire                              rst_n,
    input wire                              m_tvalid,
    input wire                              m_tready,
    input wire [tmon_pkg::M_TDATA_W-1:0]    m_tdata
);

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // alarm is one of the three codes
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[1:0] == tmon_pkg::ALARM_NONE ||
                      m_tdata[1:0] == tmon_pkg::ALARM_ABOVE ||
                      m_tdata[1:0] == tmon_pkg::ALARM_BELOW))
        else $error("bad alarm code");

    // high threshold never below low threshold
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> $signed(m_tdata[49:42]) >= $signed(m_tdata[41:34]))
        else $error("high threshold below low threshold");

    // before the first sample the window reads zero
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[50] |-> m_tdata[33:2] == 32'd0)
        else $error("window set without a sample");

    // once set, window minimum never exceeds maximum
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[50] |-> $signed(m_tdata[17:2]) <= $signed(m_tdata[33:18]))
        else $error("window min above max");

endmodule

bind temperature_threshold_monitor tmon_checker u_tmon_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

/* bench/threshold_monitor_checker.sv */
// ----------------------------------------------------------------------------
// threshold_monitor_checker: status predictor and scoreboard
// Watches the config port and both stream channels, predicts the status
// transaction for every accepted input and compares it field by field.
// ----------------------------------------------------------------------------
module threshold_monitor_checker
    import tmon_pkg::*;
(
    input  wire                      clk,
    input  wire                      rst_n,
    input  wire                      cfg_we,
    input  wire  [CFG_ADDR_W-1:0]    cfg_addr,
    input  wire  [CFG_DATA_W-1:0]    cfg_wdata,
    input  wire                      s_tvalid,
    input  wire                      s_tready,
    // command[2:0], sample_value[18:3], pad
    input  wire  [S_TDATA_W-1:0]     s_tdata,
    input  wire                      m_tvalid,
    input  wire                      m_tready,
    // alarm[1:0], min_out[17:2], max_out[33:18], low_out[41:34],
    // high_out[49:42], valid_out[50], pad
    input  wire  [M_TDATA_W-1:0]     m_tdata,
    output int                       error_count,
    output int                       outstanding
);

    typedef struct packed {
        logic [1:0]  alarm;
        logic [15:0] min_v;
        logic [15:0] max_v;
        logic [7:0]  low_v;
        logic [7:0]  high_v;
        logic        valid_v;
    } status_t;

    status_t     status_due[$];

    // configuration copy
    logic [31:0] win_len;
    int          floor_lim;
    int          ceil_lim;

    // monitor state
    int          low_thr;
    int          high_thr;
    int          win_min;
    int          win_max;
    logic        win_valid;
    logic [31:0] ticks;

    int          errors;

    // Apply one command to the monitor state and queue the status it yields.
    task automatic apply_command(input logic [2:0] cmd, input logic signed [15:0] smp);
        status_t st;
        int      s;
        int      t;
        s = smp;
        st.alarm = ALARM_NONE;
        case (cmd)
            CMD_SAMPLE:
            begin
                if (!win_valid)
                begin
                    win_min   = s;
                    win_max   = s;
                    win_valid = 1'b1;
                    ticks     = '0;
                end
                else
                begin
                    if (s > win_max) win_max = s;
                    if (s < win_min) win_min = s;
                end
                // exact compare against the scaled whole-degree threshold
                if (s > (high_thr <<< FRAC_BITS_DEF))
                    st.alarm = ALARM_ABOVE;
                else if (s < (low_thr <<< FRAC_BITS_DEF))
                    st.alarm = ALARM_BELOW;
                if (ticks >= win_len)
                begin
                    win_min = s;
                    win_max = s;
                    ticks   = '0;
                end
            end
            CMD_TICK:
            begin
                if (ticks != 32'hFFFF_FFFF)
                    ticks = ticks + 32'd1;
            end
            CMD_LOW_DOWN:
            begin
                t = low_thr - 1;
                if (t < floor_lim) t = floor_lim;
                low_thr = t;
                if (high_thr < low_thr) high_thr = low_thr;
            end
            CMD_LOW_UP:
            begin
                t = low_thr + 1;
                if (t > ceil_lim) t = ceil_lim;
                low_thr = t;
                if (high_thr < low_thr) high_thr = low_thr;
            end
            CMD_HIGH_DOWN:
            begin
                t = high_thr - 1;
                if (t < low_thr) t = low_thr;
                high_thr = t;
            end
            CMD_HIGH_UP:
            begin
                t = high_thr + 1;
                if (t > ceil_lim) t = ceil_lim;
                high_thr = t;
                if (high_thr < low_thr) high_thr = low_thr;
            end
            default:
            begin
            end
        endcase
        st.min_v   = 16'(win_min);
        st.max_v   = 16'(win_max);
        st.low_v   = 8'(low_thr);
        st.high_v  = 8'(high_thr);
        st.valid_v = win_valid;
        status_due.push_back(st);
    endtask

    always @(posedge clk)
    begin
        status_t got;
        status_t want;
        if (!rst_n)
        begin
            win_len   = WINDOW_LENGTH_RST;
            floor_lim = LIMIT_FLOOR_RST;
            ceil_lim  = LIMIT_CEILING_RST;
            low_thr   = LOW_LIMIT_RST;
            high_thr  = HIGH_LIMIT_RST;
            win_min   = 0;
            win_max   = 0;
            win_valid = 1'b0;
            ticks     = '0;
            errors    = 0;
            status_due.delete();
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got.alarm   = m_tdata[1:0];
                got.min_v   = m_tdata[17:2];
                got.max_v   = m_tdata[33:18];
                got.low_v   = m_tdata[41:34];
                got.high_v  = m_tdata[49:42];
                got.valid_v = m_tdata[50];
                if (status_due.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("status transaction with nothing pending: %h", m_tdata);
                end
                else
                begin
                    want = status_due.pop_front();
                    if (got.alarm != want.alarm || got.min_v != want.min_v
                        || got.max_v != want.max_v || got.low_v != want.low_v
                        || got.high_v != want.high_v || got.valid_v != want.valid_v)
                    begin
                        errors++;
                        if (errors <= 10)
                            $display({"status mismatch (exp/got): alarm %0d/%0d ",
                                      "min %0d/%0d max %0d/%0d low %0d/%0d ",
                                      "high %0d/%0d valid %0d/%0d"},
                                     want.alarm, got.alarm,
                                     $signed(want.min_v), $signed(got.min_v),
                                     $signed(want.max_v), $signed(got.max_v),
                                     $signed(want.low_v), $signed(got.low_v),
                                     $signed(want.high_v), $signed(got.high_v),
                                     want.valid_v, got.valid_v);
                    end
                end
            end
            if (cfg_we)
            begin
                case (cfg_addr)
                    REG_WINDOW_LENGTH: win_len   = cfg_wdata;
                    REG_LIMIT_FLOOR:   floor_lim = $signed(cfg_wdata[7:0]);
                    REG_LIMIT_CEILING: ceil_lim  = $signed(cfg_wdata[7:0]);
                    default:
                    begin
                    end
                endcase
            end
            if (s_tvalid && s_tready)
                apply_command(s_tdata[2:0], $signed(s_tdata[18:3]));
        end
        error_count <= errors;
        outstanding <= status_due.size();
    end

endmodule

/* bench/testbench.sv */
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for the temperature threshold monitor
// Directed corner transactions, then eight randomized config phases with
// bursty idling on both stream sides, a long result back-pressure and drains.
// ----------------------------------------------------------------------------
module testbench;
    import tmon_pkg::*;

    // codes the block must ignore
    localparam logic [2:0] CMD_SPARE_6 = 3'd6;
    localparam logic [2:0] CMD_SPARE_7 = 3'd7;

    localparam int ITEMS_PER_PHASE = 153;
    localparam int CYCLE_LIMIT     = 200_000;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    // command[2:0], sample_value[18:3], pad[23:19]
    logic [S_TDATA_W-1:0]  s_tdata   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    // alarm[1:0], min_out[17:2], max_out[33:18], low_out[41:34],
    // high_out[49:42], valid_out[50], pad[55:51]
    logic [M_TDATA_W-1:0]  m_tdata;

    int error_count;
    int outstanding;

    // sender / receiver pacing controls
    bit tx_idle_en    = 1'b1;
    bit rx_idle_en    = 1'b1;
    int hold_requests = 0;
    int burst_left    = 0;

    // phase settings: window length, floor, ceiling
    logic [31:0] win_setting   [8] = '{32'd3, 32'd1, 32'd0, 32'hFFFF_FFFF,
                                       32'd5, 32'd2, 32'd7, 32'd4};
    int          floor_setting [8] = '{-40, 15, -128, 127, 100, 20, -128, 120};
    int          ceil_setting  [8] = '{125, 35, 127, -128, -100, 22, -120, 127};

    temperature_threshold_monitor DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    threshold_monitor_checker scoreboard (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_addr    (cfg_addr),
        .cfg_wdata   (cfg_wdata),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .error_count (error_count),
        .outstanding (outstanding)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Watchdog: a hang or a lost transaction ends here.
    int cycles = 0;
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("[temperature_threshold_monitor] ERROR");
            $finish;
        end
    end

    // Result side. A hold request forces a long stall so the input register
    // fills and s_tready drops; otherwise short random stall bursts.
    int hold_seen  = 0;
    int stall_left = 0;
    always @(posedge clk)
    begin
        if (hold_seen != hold_requests)
        begin
            hold_seen  = hold_requests;
            stall_left = 64;
        end
        else if (stall_left == 0 && rx_idle_en && $urandom_range(0, 9) == 0)
            stall_left = $urandom_range(1, 9);
        if (stall_left > 0)
        begin
            stall_left--;
            m_tready <= 1'b0;
        end
        else
            m_tready <= 1'b1;
    end

    // One input transaction, optionally preceded by an idle burst. Valid stays
    // high between back-to-back transactions.
    task automatic send_item(input logic [2:0] cmd, input logic [15:0] smp);
        if (tx_idle_en && burst_left == 0 && $urandom_range(0, 5) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
        if (burst_left > 0)
            burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= {5'd0, smp, cmd};
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    // Stop sending and wait until every predicted status has come back.
    // The first edge lets the scoreboard count the last accepted transaction.
    task automatic drain;
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    // Register write; only issued while the block is idle.
    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [31:0] val);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(posedge clk);
    endtask

    initial
    begin
        int          hi_at;
        int          lo_at;
        int          lo_deg;
        int          hi_deg;
        int          pick;
        logic [2:0]  cmd;
        logic [15:0] smp;

        hi_at = int'(HIGH_LIMIT_RST) <<< FRAC_BITS_DEF;
        lo_at = int'(LOW_LIMIT_RST) <<< FRAC_BITS_DEF;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // --- directed part ---------------------------------------------------
        // tick before any sample, then the ignored codes with odd payloads
        send_item(CMD_TICK, 16'h0000);
        send_item(CMD_SPARE_6, 16'hFFFF);
        send_item(CMD_SPARE_7, 16'h8000);
        // first sample seeds min/max; compares exactly at both thresholds
        send_item(CMD_SAMPLE, 16'(hi_at));
        send_item(CMD_SAMPLE, 16'(hi_at + 1));
        send_item(CMD_SAMPLE, 16'(lo_at));
        send_item(CMD_SAMPLE, 16'(lo_at - 1));
        // sample extremes
        send_item(CMD_SAMPLE, 16'h8000);
        send_item(CMD_SAMPLE, 16'h7FFF);
        send_item(CMD_SAMPLE, 16'h0000);
        send_item(CMD_SAMPLE, 16'hFFFF);
        // each button once
        send_item(CMD_LOW_UP, 16'h0000);
        send_item(CMD_HIGH_DOWN, 16'h0000);
        send_item(CMD_LOW_DOWN, 16'h0000);
        send_item(CMD_HIGH_UP, 16'h0000);

        // narrow limits around the thresholds: clamps at floor and ceiling,
        // low up pinned at the ceiling, high down pinned at the low threshold
        drain();
        write_reg(REG_LIMIT_FLOOR, 32'd17);
        write_reg(REG_LIMIT_CEILING, 32'd19);
        send_item(CMD_LOW_DOWN, 16'h0000);
        send_item(CMD_LOW_DOWN, 16'h0000);
        send_item(CMD_HIGH_UP, 16'h0000);
        send_item(CMD_LOW_UP, 16'h0000);
        send_item(CMD_LOW_UP, 16'h0000);
        send_item(CMD_LOW_UP, 16'h0000);
        send_item(CMD_HIGH_DOWN, 16'h0000);

        // one-tick window: the next sample restarts min/max
        drain();
        write_reg(REG_WINDOW_LENGTH, 32'd1);
        send_item(CMD_TICK, 16'h0000);
        send_item(CMD_SAMPLE, 16'd100);
        send_item(CMD_SAMPLE, 16'(-5000));

        // --- random phases ---------------------------------------------------
        for (int p = 0; p < 8; p++)
        begin
            drain();
            write_reg(REG_WINDOW_LENGTH, win_setting[p]);
            write_reg(REG_LIMIT_FLOOR, {24'd0, 8'(floor_setting[p])});
            write_reg(REG_LIMIT_CEILING, {24'd0, 8'(ceil_setting[p])});
            lo_deg = (floor_setting[p] < ceil_setting[p]) ? floor_setting[p] : ceil_setting[p];
            hi_deg = (floor_setting[p] < ceil_setting[p]) ? ceil_setting[p] : floor_setting[p];
            // two phases run with no idling at all, the last one among them
            tx_idle_en = (p != 4 && p != 7);
            rx_idle_en <= (p != 4 && p != 7);

            for (int i = 0; i < ITEMS_PER_PHASE; i++)
            begin
                // long result stall while the sender keeps pushing
                if (p == 1 && i == 40)
                begin
                    hold_requests <= hold_requests + 1;
                    burst_left = 24;
                end
                // now and then wait for the pipeline to empty mid-phase
                if (p != 7 && burst_left == 0 && $urandom_range(0, 99) == 0)
                    drain();

                pick = $urandom_range(0, 99);
                if (pick < 40)
                    cmd = CMD_SAMPLE;
                else if (pick < 60)
                    cmd = CMD_TICK;
                else if (pick < 68)
                    cmd = CMD_LOW_DOWN;
                else if (pick < 76)
                    cmd = CMD_LOW_UP;
                else if (pick < 84)
                    cmd = CMD_HIGH_DOWN;
                else if (pick < 92)
                    cmd = CMD_HIGH_UP;
                else if (pick < 96)
                    cmd = CMD_SPARE_6;
                else
                    cmd = CMD_SPARE_7;

                // half the samples land within two LSBs of a whole degree
                // inside the phase limits, where the thresholds live
                pick = $urandom_range(0, 99);
                if (pick < 50)
                    smp = 16'(((int'($urandom_range(0, hi_deg - lo_deg)) + lo_deg)
                               <<< FRAC_BITS_DEF) + int'($urandom_range(0, 4)) - 2);
                else if (pick < 85)
                    smp = 16'($urandom);
                else
                begin
                    case ($urandom_range(0, 3))
                        0:       smp = 16'h8000;
                        1:       smp = 16'h7FFF;
                        2:       smp = 16'h0000;
                        default: smp = 16'hFFFF;
                    endcase
                end
                send_item(cmd, smp);
            end
        end

        drain();
        repeat (4) @(posedge clk);
        if (error_count == 0 && outstanding == 0)
            $display("[temperature_threshold_monitor] OK");
        else
            $display("[temperature_threshold_monitor] ERROR");
        $finish;
    end

endmodule
